>>> sv/lfr_pkg.sv
`timescale 1ns / 1ps

package lfr_pkg;

  // Frame buffer geometry
  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = ADDR_W + 1;

  // Received byte decoding
  localparam logic [7:0] OPCODE_FLAG  = 8'h80;
  localparam logic [7:0] GOOD_XOR     = 8'hFF;
  localparam logic [7:0] MIN_VAR_LEN  = 8'd3;
  localparam logic [7:0] MAX_VAR_LEN  = 8'(BUF_DEPTH);

  // Opcode bits 6:5 select the frame length
  typedef enum logic [1:0] {
    LEN_TWO  = 2'b00,
    LEN_FOUR = 2'b01,
    LEN_SIX  = 2'b10,
    LEN_VAR  = 2'b11
  } len_code_e;

  localparam logic [ADDR_W-1:0] LAST_TWO  = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] LAST_FOUR = ADDR_W'(3);
  localparam logic [ADDR_W-1:0] LAST_SIX  = ADDR_W'(5);

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_CSUM    = 2'd1,
    ST_LENGTH  = 2'd2,
    ST_ABANDON = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ERROR  = 1'b0,
    CMD_REPLAY = 1'b1
  } cmd_kind_e;

  // Request from the front to the back
  typedef struct packed {
    cmd_kind_e         kind;
    logic [ADDR_W-1:0] index;
    logic [LEN_W-1:0]  length;
    status_e           status;
  } cmd_t;

  // Frame buffer write from the front
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // Status from the back to the front
  typedef struct packed {
    logic done;
  } back_stat_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_EMIT = 2'd2
  } back_state_e;

endpackage

>>> sv/lfr_front.sv
`timescale 1ns / 1ps

module lfr_front import lfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  back_stat_t back_stat_i,
  output logic       busy_o,
  output logic       cmd_push_o,
  output cmd_t       cmd_o,
  output wr_t        wr_o
);

  logic              in_frame_q, in_frame_d;
  logic              pending_q, pending_d;
  logic [LEN_W-1:0]  wp_q, wp_d;
  logic [ADDR_W-1:0] last_q, last_d;
  logic [7:0]        xor_q, xor_d;
  logic              busy_q, busy_d;

  // Frame parser
  always_comb begin
    logic              do_store;
    logic [LEN_W-1:0]  wp_base;
    logic [7:0]        xor_base;
    logic [LEN_W-1:0]  wp_new;
    logic [7:0]        xor_new;
    do_store   = 1'b0;
    wp_base    = wp_q;
    xor_base   = xor_q;
    wp_new     = '0;
    xor_new    = '0;
    in_frame_d = in_frame_q;
    pending_d  = pending_q;
    wp_d       = wp_q;
    last_d     = last_q;
    xor_d      = xor_q;
    busy_d     = busy_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: CMD_ERROR, index: '0, length: '0, status: ST_GOOD};
    wr_o       = '0;

    if (back_stat_i.done) begin
      busy_d = 1'b0;
    end

    if (accept_i) begin
      if ((rx_byte_i & OPCODE_FLAG) != 8'h00) begin
        // new opcode abandons any open frame
        if (in_frame_q) begin
          cmd_push_o    = 1'b1;
          cmd_o.status  = ST_ABANDON;
          cmd_o.index   = (wp_q != '0) ? ADDR_W'(wp_q - LEN_W'(1)) : '0;
          cmd_o.length  = pending_q ? '0 : ({1'b0, last_q} + LEN_W'(1));
        end
        wp_base    = '0;
        xor_base   = '0;
        in_frame_d = 1'b1;
        pending_d  = 1'b0;
        case (len_code_e'(rx_byte_i[6:5]))
          LEN_TWO:  last_d = LAST_TWO;
          LEN_FOUR: last_d = LAST_FOUR;
          LEN_SIX:  last_d = LAST_SIX;
          default: begin
            last_d    = '0;
            pending_d = 1'b1;
          end
        endcase
        do_store = 1'b1;
      end else if (in_frame_q) begin
        if (pending_q) begin
          pending_d = 1'b0;
          if (rx_byte_i < MIN_VAR_LEN || rx_byte_i > MAX_VAR_LEN) begin
            in_frame_d   = 1'b0;
            cmd_push_o   = 1'b1;
            cmd_o.status = ST_LENGTH;
            cmd_o.index  = wp_q[ADDR_W-1:0];
            cmd_o.length = '0;
          end else begin
            last_d   = ADDR_W'(rx_byte_i - 8'd1);
            do_store = 1'b1;
          end
        end else begin
          do_store = 1'b1;
        end
      end
    end

    // store byte and check for frame end; no end while the count is awaited
    if (do_store) begin
      wr_o.en   = 1'b1;
      wr_o.addr = wp_base[ADDR_W-1:0];
      wr_o.data = rx_byte_i;
      xor_new   = xor_base ^ rx_byte_i;
      wp_new    = wp_base + LEN_W'(1);
      xor_d     = xor_new;
      wp_d      = wp_new;
      if (!pending_d && wp_new > {1'b0, last_d}) begin
        in_frame_d   = 1'b0;
        cmd_push_o   = 1'b1;
        cmd_o.index  = last_d;
        cmd_o.length = {1'b0, last_d} + LEN_W'(1);
        if (xor_new == GOOD_XOR) begin
          cmd_o.kind   = CMD_REPLAY;
          cmd_o.status = ST_GOOD;
          busy_d       = 1'b1;
        end else begin
          cmd_o.status = ST_CSUM;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pending_q  <= 1'b0;
      wp_q       <= '0;
      last_q     <= '0;
      xor_q      <= '0;
      busy_q     <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      pending_q  <= pending_d;
      wp_q       <= wp_d;
      last_q     <= last_d;
      xor_q      <= xor_d;
      busy_q     <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

>>> sv/lfr_cmd_fifo.sv
`timescale 1ns / 1ps

module lfr_cmd_fifo import lfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int DEPTH = 2;

  cmd_t       mem_q [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  // Two-entry request queue
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == 2'(DEPTH));
  assign empty_o = (count_q == '0);

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'(DEPTH))
    else $error("request queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full request queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty request queue");
`endif

endmodule

>>> sv/lfr_back.sv
`timescale 1ns / 1ps

module lfr_back import lfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wr_t               wr_i,
  input  cmd_t              cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output back_stat_t        back_stat_o,
  output logic              out_valid_o,
  input  logic              out_pop_i,
  output logic [7:0]        frame_byte_o,
  output logic [ADDR_W-1:0] byte_index_o,
  output logic [LEN_W-1:0]  frame_length_o,
  output logic [1:0]        status_o,
  output logic              last_of_frame_o
);

  logic [7:0]        store_q [BUF_DEPTH];
  logic [7:0]        rd_data_q;

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] last_q, last_d;
  logic [LEN_W-1:0]  len_q, len_d;

  logic              out_valid_q, out_valid_d;
  logic              can_load;
  logic              load;
  logic [7:0]        byte_d, byte_q;
  logic [ADDR_W-1:0] idx_d, idx_q;
  logic [LEN_W-1:0]  olen_d, olen_q;
  status_e           stat_d, stat_q;
  logic              olast_d, olast_q;

  // Frame buffer, registered read at the replay pointer
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= store_q[ptr_q];
  end

  assign can_load = !out_valid_q || out_pop_i;

  // Replay sequencer
  always_comb begin
    state_d          = state_q;
    ptr_d            = ptr_q;
    last_d           = last_q;
    len_d            = len_q;
    cmd_pop_o        = 1'b0;
    back_stat_o.done = 1'b0;
    load             = 1'b0;
    byte_d           = '0;
    idx_d            = '0;
    olen_d           = '0;
    stat_d           = ST_GOOD;
    olast_d          = 1'b1;
    case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.kind == CMD_REPLAY) begin
            cmd_pop_o = 1'b1;
            ptr_d     = '0;
            last_d    = cmd_i.index;
            len_d     = cmd_i.length;
            state_d   = B_READ;
          end else if (can_load) begin
            cmd_pop_o = 1'b1;
            load      = 1'b1;
            idx_d     = cmd_i.index;
            olen_d    = cmd_i.length;
            stat_d    = cmd_i.status;
          end
        end
      end
      B_READ: begin
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (can_load) begin
          load    = 1'b1;
          byte_d  = rd_data_q;
          idx_d   = ptr_q;
          olen_d  = len_q;
          olast_d = (ptr_q == last_q);
          if (ptr_q == last_q) begin
            back_stat_o.done = 1'b1;
            state_d          = B_IDLE;
          end else begin
            ptr_d   = ptr_q + ADDR_W'(1);
            state_d = B_READ;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_pop_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ptr_q       <= '0;
      last_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      last_q      <= last_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= byte_d;
      idx_q   <= idx_d;
      olen_q  <= olen_d;
      stat_q  <= stat_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = byte_q;
  assign byte_index_o    = idx_q;
  assign frame_length_o  = olen_q;
  assign status_o        = stat_q;
  assign last_of_frame_o = olast_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT || state_q == B_READ) |-> ptr_q <= last_q)
    else $error("replay pointer beyond frame end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == B_IDLE)
    else $error("request taken while replay in progress");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat_o.done |=> (state_q == B_IDLE && out_valid_q && olast_q))
    else $error("replay finished without final result");
`endif

endmodule

>>> sv/loconet_frame_receiver.sv
`timescale 1ns / 1ps
// LocoNet frame receiver.
// Input channel: write one received byte on rx_byte_i with push; it is taken
// on a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result is on the output
// ports; pop takes it. A good frame comes out one byte per result with
// status good and last_of_frame_o on its final byte; a bad or abandoned
// frame gives a single error result.
// An error result goes through the request queue into the result register.
// A good frame is replayed from the frame buffer one byte at a time, each
// byte first read from memory and then loaded into the result register,
// and the next byte is read only after the current one is loaded. The
// replay waits while the result register holds a result pop has not taken.
// Throughput: one byte per cycle while a frame is being collected and full
// is low. Once a good frame is complete, full stays high until its final
// byte is loaded into the result register, which takes longer if pop is
// held low. A two-entry request queue sits between parser and replay unit;
// if pop is held low, results stay put and full rises once that queue
// fills.
// Reset clears the parser (no frame open), the queue and the result valid
// flag; the frame buffer itself is not cleared.

module loconet_frame_receiver import lfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] frame_byte_o,
  output logic [4:0] byte_index_o,
  output logic [5:0] frame_length_o,
  output logic [1:0] status_o,
  output logic       last_of_frame_o
);

  logic       accept;
  logic       front_busy;
  logic       cmd_push;
  cmd_t       cmd_in;
  cmd_t       cmd_out;
  logic       cmd_full;
  logic       cmd_empty;
  logic       cmd_pop;
  wr_t        wr;
  back_stat_t back_stat;
  logic       out_valid;

  assign full   = front_busy || cmd_full;
  assign accept = push && !full;
  assign empty  = !out_valid;

  lfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .back_stat_i (back_stat),
    .busy_o      (front_busy),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .wr_o        (wr)
  );

  lfr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  lfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .cmd_i           (cmd_out),
    .cmd_empty_i     (cmd_empty),
    .cmd_pop_o       (cmd_pop),
    .back_stat_o     (back_stat),
    .out_valid_o     (out_valid),
    .out_pop_i       (pop),
    .frame_byte_o    (frame_byte_o),
    .byte_index_o    (byte_index_o),
    .frame_length_o  (frame_length_o),
    .status_o        (status_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
